/* design/ppmr_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ppmr_pkg
// Shared types and constants for the P6 raster sample rescaler.
// ----------------------------------------------------------------------------
package ppmr_pkg;

    localparam int CountBits = 24;
    localparam int DivSteps  = 8;

    localparam logic [7:0] FullScale = 8'hFF;

    localparam logic [1:0] ChRed   = 2'd0;
    localparam logic [1:0] ChGreen = 2'd1;
    localparam logic [1:0] ChBlue  = 2'd2;

    localparam logic CfgMaxValue   = 1'b0;
    localparam logic CfgPixelCount = 1'b1;

    typedef struct packed {
        logic [15:0] rem;
        logic [7:0]  low;
        logic [7:0]  quo;
        logic [15:0] divisor;
        logic        bypass;
        logic [7:0]  bypass_sample;
        logic [1:0]  channel;
        logic        last;
        logic        over;
    } t_item;

endpackage : ppmr_pkg
`default_nettype wire

/* design/ppm_sample_rescale_to_8bit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ppm_sample_rescale_to_8bit
// P6 raster bytes to 8-bit RGB samples, rescaled by (v*255 + max/2)/max.
// ----------------------------------------------------------------------------
//  channel  direction  handshake          payload
//  in       sink       i_valid / o_stall  i_data_byte
//  out      source     o_valid / i_stall  o_sample, o_channel, o_image_last,
//                                         o_over_range
//  cfg      sink       i_cfg_wr_en        i_cfg_index, i_cfg_wr_data
//
//  One byte transfer per cycle while o_stall is low; a sample's result passes
//  through the front stage, eight divider cells and the output register
//  before o_valid rises.
//  The eight-cell divider chain holds one item in each cell.
//  Stages collapse bubbles, so o_stall rises only when every stage is full.
//  Synchronous active-low reset clears counters, byte phase and all valids.
// ----------------------------------------------------------------------------
module ppm_sample_rescale_to_8bit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_data_byte,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [7:0]       o_sample,
    output logic [1:0]       o_channel,
    output logic             o_image_last,
    output logic             o_over_range,
    input  wire logic        i_cfg_wr_en,
    input  wire logic        i_cfg_index,
    input  wire logic [23:0] i_cfg_wr_data
);

    logic [15:0]                    r_max_value;
    logic [ppmr_pkg::CountBits-1:0] r_pixel_count;

    logic                           r_out_valid;
    logic [7:0]                     r_sample;
    logic [1:0]                     r_channel;
    logic                           r_last;
    logic                           r_over;

    logic                           front_ready;
    logic                           out_ready;
    logic            cell_valid [0:ppmr_pkg::DivSteps];
    logic            cell_ready [0:ppmr_pkg::DivSteps];
    ppmr_pkg::t_item cell_item  [0:ppmr_pkg::DivSteps];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_value   <= 16'd255;
            r_pixel_count <= {{(ppmr_pkg::CountBits-1){1'b0}}, 1'b1};
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                ppmr_pkg::CfgMaxValue:   r_max_value   <= i_cfg_wr_data[15:0];
                ppmr_pkg::CfgPixelCount: r_pixel_count <= i_cfg_wr_data[23:0];
                default: ;
            endcase
        end
    end

    ppmr_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_data_byte   (i_data_byte),
        .i_max_value   (r_max_value),
        .i_pixel_count (r_pixel_count),
        .i_ready       (cell_ready[0]),
        .o_ready       (front_ready),
        .o_valid       (cell_valid[0]),
        .o_item        (cell_item[0])
    );

    for (genvar k = 0; k < ppmr_pkg::DivSteps; k++) begin : g_cell
        ppmr_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (cell_valid[k]),
            .i_item  (cell_item[k]),
            .i_ready (cell_ready[k+1]),
            .o_ready (cell_ready[k]),
            .o_valid (cell_valid[k+1]),
            .o_item  (cell_item[k+1])
        );
    end

    assign out_ready                       = !r_out_valid || !i_stall;
    assign cell_ready[ppmr_pkg::DivSteps]  = out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= cell_valid[ppmr_pkg::DivSteps];
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready) begin
            r_sample  <= cell_item[ppmr_pkg::DivSteps].bypass
                       ? cell_item[ppmr_pkg::DivSteps].bypass_sample
                       : cell_item[ppmr_pkg::DivSteps].quo;
            r_channel <= cell_item[ppmr_pkg::DivSteps].channel;
            r_last    <= cell_item[ppmr_pkg::DivSteps].last;
            r_over    <= cell_item[ppmr_pkg::DivSteps].over;
        end
    end

    assign o_stall      = !front_ready;
    assign o_valid      = r_out_valid;
    assign o_sample     = r_sample;
    assign o_channel    = r_channel;
    assign o_image_last = r_last;
    assign o_over_range = r_over;

`ifndef NO_ASSERTIONS
    a_over_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_over_range |-> o_sample == ppmr_pkg::FullScale)
        else $error("saturated sample not full scale");

    a_last_blue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_image_last |-> o_channel == ppmr_pkg::ChBlue)
        else $error("image end flagged off the blue sample");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled while output free");

    a_chan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_channel != 2'd3)
        else $error("channel tag out of range");
`endif

endmodule : ppm_sample_rescale_to_8bit
`default_nettype wire

/* design/ppmr_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ppmr_front
// Byte assembly, colour and pixel counting, numerator build for the divider.
// ----------------------------------------------------------------------------
module ppmr_front (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    input  wire logic [7:0]                      i_data_byte,
    input  wire logic [15:0]                     i_max_value,
    input  wire logic [ppmr_pkg::CountBits-1:0]  i_pixel_count,
    input  wire logic                            i_ready,
    output logic                                 o_ready,
    output logic                                 o_valid,
    output ppmr_pkg::t_item                      o_item
);

    logic                           r_phase;
    logic [7:0]                     r_held;
    logic [1:0]                     r_colour;
    logic [ppmr_pkg::CountBits-1:0] r_pixel;
    logic                           r_valid;
    ppmr_pkg::t_item                r_item;

    logic                           n_phase;
    logic [7:0]                     n_held;
    logic [1:0]                     n_colour;
    logic [ppmr_pkg::CountBits-1:0] n_pixel;
    ppmr_pkg::t_item                n_item;

    logic                           accept;
    logic                           two_byte;
    logic                           has_result;
    logic [15:0]                    v;
    logic [15:0]                    eff_max;
    logic                           over;
    logic [23:0]                    v24;
    logic [23:0]                    num;
    logic [ppmr_pkg::CountBits-1:0] last_index;
    logic                           is_last;

    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;

    always_comb begin
        two_byte   = (i_max_value[15:8] != 8'd0);
        v          = two_byte ? {r_held, i_data_byte} : {8'd0, i_data_byte};
        has_result = !two_byte || r_phase;
        eff_max    = (i_max_value == 16'd0) ? 16'd1 : i_max_value;
        over       = (v > eff_max);
        v24        = {8'd0, v};
        num        = (v24 << 8) - v24 + {9'd0, eff_max[15:1]};
        last_index = i_pixel_count - {{(ppmr_pkg::CountBits-1){1'b0}}, 1'b1};
        is_last    = (r_colour == ppmr_pkg::ChBlue) && (r_pixel >= last_index);

        n_item.rem           = num[23:8];
        n_item.low           = num[7:0];
        n_item.quo           = 8'd0;
        n_item.divisor       = eff_max;
        n_item.bypass        = over || (eff_max == {8'd0, ppmr_pkg::FullScale});
        n_item.bypass_sample = over ? ppmr_pkg::FullScale : v[7:0];
        n_item.channel       = r_colour;
        n_item.last          = is_last;
        n_item.over          = over;
    end

    always_comb begin
        n_phase  = r_phase;
        n_held   = r_held;
        n_colour = r_colour;
        n_pixel  = r_pixel;
        if (accept) begin
            if (!two_byte) begin
                n_phase = 1'b0;
            end else if (!r_phase) begin
                n_phase = 1'b1;
                n_held  = i_data_byte;
            end else begin
                n_phase = 1'b0;
            end
            if (has_result) begin
                if (r_colour == ppmr_pkg::ChBlue) begin
                    n_colour = ppmr_pkg::ChRed;
                    n_pixel  = is_last ? '0
                             : r_pixel + {{(ppmr_pkg::CountBits-1){1'b0}}, 1'b1};
                end else begin
                    n_colour = r_colour + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= 1'b0;
            r_held   <= 8'd0;
            r_colour <= ppmr_pkg::ChRed;
            r_pixel  <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_held   <= n_held;
            r_colour <= n_colour;
            r_pixel  <= n_pixel;
            if (o_ready) begin
                r_valid <= accept && has_result;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule : ppmr_front
`default_nettype wire

/* design/ppmr_div_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ppmr_div_cell
// One restoring division step: shifts in a numerator bit, yields a quotient bit.
// ----------------------------------------------------------------------------
module ppmr_div_cell (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  ppmr_pkg::t_item       i_item,
    input  wire logic             i_ready,
    output logic                  o_ready,
    output logic                  o_valid,
    output ppmr_pkg::t_item       o_item
);

    logic            r_valid;
    ppmr_pkg::t_item r_item;
    ppmr_pkg::t_item n_item;

    logic [16:0] trial;
    logic [16:0] diff;
    logic        ge;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        trial  = {i_item.rem, i_item.low[7]};
        diff   = trial - {1'b0, i_item.divisor};
        ge     = (trial >= {1'b0, i_item.divisor});
        n_item = i_item;
        n_item.rem = ge ? diff[15:0] : trial[15:0];
        n_item.low = {i_item.low[6:0], 1'b0};
        n_item.quo = {i_item.quo[6:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule : ppmr_div_cell
`default_nettype wire

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Checks the P6 raster rescaler against a cycle-free prediction of the sample
// stream. Directed bytes cover the extremes and corner cases first. Random
// images follow at varied settings, with random idling on both sides and one
// long output hold-off.
// ----------------------------------------------------------------------------
module testbench;

    localparam int LimitCycles = 400000;
    localparam int DrainCycles = 16;
    localparam int RandomBytes = 850;
    localparam int FillBytes   = 48;

    typedef struct packed {
        logic [7:0] sample;
        logic [1:0] channel;
        logic       last;
        logic       over;
    } t_rgb_sample;

    class t_rescale_board;
        logic [15:0]    max_value;
        logic [23:0]    pixel_count;
        logic           byte_phase;
        logic [7:0]     held_byte;
        logic [1:0]     colour;
        logic [23:0]    pixel_index;
        t_rgb_sample    due_samples[$];
        int             errors;

        function new();
            max_value   = 16'd255;
            pixel_count = 24'd1;
            byte_phase  = 1'b0;
            held_byte   = 8'h00;
            colour      = ppmr_pkg::ChRed;
            pixel_index = '0;
            errors      = 0;
        endfunction

        function void set_reg(logic idx, logic [23:0] data);
            if (idx == ppmr_pkg::CfgMaxValue)
                max_value = data[15:0];
            else
                pixel_count = data;
        endfunction

        function int pending();
            return due_samples.size();
        endfunction

        function void take_byte(logic [7:0] b);
            logic [15:0]    v;
            logic [15:0]    lim;
            int unsigned    q;
            t_rgb_sample    r;
            logic [23:0]    last_idx;
            if (max_value < 16'd256) begin
                byte_phase = 1'b0;
                v = {8'h00, b};
            end else if (!byte_phase) begin
                held_byte  = b;
                byte_phase = 1'b1;
                return;
            end else begin
                byte_phase = 1'b0;
                v = {held_byte, b};
            end
            lim = (max_value == 16'd0) ? 16'd1 : max_value;
            if (v > lim) begin
                r.sample = ppmr_pkg::FullScale;
                r.over   = 1'b1;
            end else begin
                r.over = 1'b0;
                if (lim == 16'd255) begin
                    r.sample = v[7:0];
                end else begin
                    q = (int'(v) * 255 + int'(lim >> 1)) / int'(lim);
                    r.sample = q[7:0];
                end
            end
            r.channel = colour;
            r.last    = 1'b0;
            last_idx  = pixel_count - 24'd1;
            if (colour >= ppmr_pkg::ChBlue) begin
                if (pixel_index >= last_idx) begin
                    r.last      = 1'b1;
                    pixel_index = '0;
                end else begin
                    pixel_index = pixel_index + 24'd1;
                end
                colour = ppmr_pkg::ChRed;
            end else begin
                colour = colour + 2'd1;
            end
            due_samples = {due_samples, r};
        endfunction

        function void compare_sample(logic [7:0] s, logic [1:0] ch, logic last, logic over);
            t_rgb_sample r;
            if (due_samples.size() == 0) begin
                $display("%0t: unexpected sample %0d channel %0d", $time, s, ch);
                errors++;
                return;
            end
            r = due_samples.pop_front();
            if (s !== r.sample) begin
                $display("%0t: sample expected %0d got %0d", $time, r.sample, s);
                errors++;
            end
            if (ch !== r.channel) begin
                $display("%0t: channel expected %0d got %0d", $time, r.channel, ch);
                errors++;
            end
            if (last !== r.last) begin
                $display("%0t: image_last expected %0d got %0d", $time, r.last, last);
                errors++;
            end
            if (over !== r.over) begin
                $display("%0t: over_range expected %0d got %0d", $time, r.over, over);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_data_byte = 8'h00;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [7:0]  o_sample;
    logic [1:0]  o_channel;
    logic        o_image_last;
    logic        o_over_range;
    logic        i_cfg_wr_en = 1'b0;
    logic        i_cfg_index = ppmr_pkg::CfgMaxValue;
    logic [23:0] i_cfg_wr_data = '0;

    t_rescale_board board;
    bit          tx_gaps;
    bit          rx_gaps;
    bit          hold_long;
    int          cycles;
    int          sent_bytes;

    ppm_sample_rescale_to_8bit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_data_byte   (i_data_byte),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_sample      (o_sample),
        .o_channel     (o_channel),
        .o_image_last  (o_image_last),
        .o_over_range  (o_over_range),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LimitCycles) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // output side: check each transfer, then pick the next stall
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid === 1'b1 && !i_stall)
                board.compare_sample(o_sample, o_channel, o_image_last, o_over_range);
            if (hold_long) begin
                hold_long = 1'b0;
                hold_left = 59;
                i_stall <= 1'b1;
            end else if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (rx_gaps && $urandom_range(0, 7) == 0) begin
                hold_left = $urandom_range(0, 10);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    task automatic send_byte(logic [7:0] b);
        if (tx_gaps && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= b;
        do @(posedge i_clk); while (o_stall);
        board.take_byte(b);
        sent_bytes++;
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [23:0] data);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_index   <= idx;
        i_cfg_wr_data <= data;
        @(posedge i_clk);
        board.set_reg(idx, data);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_image(int nbytes);
        logic [7:0]  b;
        logic [15:0] mx;
        bit          high_next;
        mx        = board.max_value;
        high_next = !board.byte_phase;
        repeat (nbytes) begin
            if (mx < 16'd256) begin
                b = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                                : 8'($urandom_range(0, mx));
            end else if (high_next) begin
                b = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                : 8'($urandom_range(0, mx >> 8));
            end else begin
                b = 8'($urandom_range(0, 255));
            end
            send_byte(b);
            if (mx >= 16'd256)
                high_next = !high_next;
        end
    endtask

    initial begin
        logic [15:0] mx;
        logic [23:0] pc;
        int          pick;
        int          nbytes;
        board = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: pass-through at reset settings, one pixel per image
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(8'h01);
        send_byte(8'h7E);
        settle();
        // max of one, saturation on anything above
        write_reg(ppmr_pkg::CfgMaxValue, 24'd1);
        write_reg(ppmr_pkg::CfgPixelCount, 24'd2);
        send_byte(8'h00);
        send_byte(8'h01);
        send_byte(8'h02);
        send_byte(8'hFF);
        settle();
        // max of zero behaves as one
        write_reg(ppmr_pkg::CfgMaxValue, 24'd0);
        send_byte(8'h01);
        send_byte(8'h02);
        settle();
        // two-byte samples, full range, pixel count zero
        write_reg(ppmr_pkg::CfgMaxValue, 24'd65535);
        write_reg(ppmr_pkg::CfgPixelCount, 24'd0);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h00);
        settle();
        write_reg(ppmr_pkg::CfgMaxValue, 24'd256);
        write_reg(ppmr_pkg::CfgPixelCount, 24'hFFFFFF);
        send_byte(8'h01);
        send_byte(8'h00);
        send_byte(8'h01);
        send_byte(8'h01);
        send_byte(8'h7F);
        settle();
        // held high byte dropped on the switch to one byte; count lowered mid-image
        write_reg(ppmr_pkg::CfgMaxValue, 24'd100);
        write_reg(ppmr_pkg::CfgPixelCount, 24'd1);
        send_byte(8'h64);
        send_byte(8'h65);
        send_byte(8'h32);
        settle();

        sent_bytes = 0;
        while (sent_bytes < RandomBytes) begin
            pick = $urandom_range(0, 9);
            if (pick < 4)
                mx = ($urandom_range(0, 3) == 0) ? 16'(($urandom_range(0, 1) == 0) ? 1 : 255)
                                                 : 16'($urandom_range(2, 254));
            else if (pick < 9)
                mx = ($urandom_range(0, 3) == 0) ? 16'(($urandom_range(0, 1) == 0) ? 256 : 65535)
                                                 : 16'($urandom_range(257, 65534));
            else
                mx = 16'd0;
            pick = $urandom_range(0, 9);
            if (pick < 7)
                pc = 24'($urandom_range(1, 6));
            else if (pick == 7)
                pc = 24'($urandom_range(0, 1) == 0 ? 0 : 24'hFFFFFF);
            else
                pc = 24'($urandom_range(0, 24'hFFFFFF));
            if ($urandom_range(0, 3) != 0)
                write_reg(ppmr_pkg::CfgMaxValue, {8'h00, mx});
            write_reg(ppmr_pkg::CfgPixelCount, pc);
            nbytes = $urandom_range(6, 48);
            if (sent_bytes >= RandomBytes - 120) begin
                tx_gaps = 0;
                rx_gaps = 0;
            end else if (sent_bytes == 0) begin
                // output held back while input keeps coming, so the pipe fills
                tx_gaps   = 0;
                rx_gaps   = 0;
                hold_long = 1'b1;
                nbytes    = FillBytes;
            end else begin
                tx_gaps = $urandom_range(0, 3) != 0;
                rx_gaps = $urandom_range(0, 3) != 0;
            end
            send_image(nbytes);
            settle();
        end

        if (board.errors == 0 && board.pending() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
